>>> sv/ctbc_pkg.sv
package ctbc_pkg;

    // pipeline depth from accepted input to registered result
    localparam int NUM_STAGES = 4;

    typedef enum logic [1:0] {
        MODE_BOX_BOX       = 2'd0,
        MODE_CIRCLE_CIRCLE = 2'd1,
        MODE_BOX_CIRCLE    = 2'd2
    } t_mode;

    // control that travels down the pipe beside the datapath
    typedef struct packed {
        t_mode mode;
        logic  box_hit;
    } t_ctl;

endpackage

>>> sv/ctbc_clamp.sv
module ctbc_clamp
    import ctbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [1:0]                    i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_a_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_hi_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_hi_y,
    output t_ctl                          o_ctl,
    output logic signed [COORD_WIDTH-1:0] o_px,
    output logic signed [COORD_WIDTH-1:0] o_qx,
    output logic signed [COORD_WIDTH-1:0] o_py,
    output logic signed [COORD_WIDTH-1:0] o_qy,
    output logic [COORD_WIDTH-1:0]        o_rs
);

    t_mode                          mode;
    logic signed [COORD_WIDTH-1:0]  tx, ty, cx, cy;
    logic [COORD_WIDTH-2:0]         ra, rb;
    logic                           apart;

    t_ctl                           n_ctl, r_ctl;
    logic signed [COORD_WIDTH-1:0]  n_px, n_qx, n_py, n_qy;
    logic signed [COORD_WIDTH-1:0]  r_px, r_qx, r_py, r_qy;
    logic [COORD_WIDTH-1:0]         n_rs, r_rs;

    always_comb begin
        mode  = t_mode'(i_mode);
        apart = (i_a_hi_x < i_b_lo_x) || (i_a_lo_x > i_b_hi_x) ||
                (i_a_hi_y < i_b_lo_y) || (i_a_lo_y > i_b_hi_y);

        // clamp circle centre into the box: max(lo, min(c, hi))
        tx = (i_b_lo_x < i_a_hi_x) ? i_b_lo_x : i_a_hi_x;
        cx = (i_a_lo_x > tx) ? i_a_lo_x : tx;
        ty = (i_b_lo_y < i_a_hi_y) ? i_b_lo_y : i_a_hi_y;
        cy = (i_a_lo_y > ty) ? i_a_lo_y : ty;

        // negative radius counts as zero
        ra = i_a_hi_x[COORD_WIDTH-1] ? '0 : i_a_hi_x[COORD_WIDTH-2:0];
        rb = i_b_hi_x[COORD_WIDTH-1] ? '0 : i_b_hi_x[COORD_WIDTH-2:0];

        n_ctl.mode    = mode;
        n_ctl.box_hit = ~apart;

        if (mode == MODE_CIRCLE_CIRCLE) begin
            n_px = i_a_lo_x;
            n_qx = i_b_lo_x;
            n_py = i_a_lo_y;
            n_qy = i_b_lo_y;
            n_rs = {1'b0, ra} + {1'b0, rb};
        end else begin
            n_px = i_b_lo_x;
            n_qx = cx;
            n_py = i_b_lo_y;
            n_qy = cy;
            n_rs = {1'b0, rb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_px  <= n_px;
            r_qx  <= n_qx;
            r_py  <= n_py;
            r_qy  <= n_qy;
            r_rs  <= n_rs;
        end
    end

    assign o_ctl = r_ctl;
    assign o_px  = r_px;
    assign o_qx  = r_qx;
    assign o_py  = r_py;
    assign o_qy  = r_qy;
    assign o_rs  = r_rs;

endmodule

>>> sv/ctbc_absdiff.sv
module ctbc_absdiff
    import ctbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_ctl                          i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_qx,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_qy,
    input  logic [COORD_WIDTH-1:0]        i_rs,
    output t_ctl                          o_ctl,
    output logic [COORD_WIDTH-1:0]        o_dx,
    output logic [COORD_WIDTH-1:0]        o_dy,
    output logic [COORD_WIDTH-1:0]        o_rs
);

    logic signed [COORD_WIDTH:0] pq_x, qp_x, pq_y, qp_y;
    logic [COORD_WIDTH-1:0]      n_dx, n_dy, r_dx, r_dy, r_rs;
    t_ctl                        r_ctl;

    always_comb begin
        pq_x = {i_px[COORD_WIDTH-1], i_px} - {i_qx[COORD_WIDTH-1], i_qx};
        qp_x = {i_qx[COORD_WIDTH-1], i_qx} - {i_px[COORD_WIDTH-1], i_px};
        pq_y = {i_py[COORD_WIDTH-1], i_py} - {i_qy[COORD_WIDTH-1], i_qy};
        qp_y = {i_qy[COORD_WIDTH-1], i_qy} - {i_py[COORD_WIDTH-1], i_py};
        // magnitude of a difference always fits the coordinate width unsigned
        n_dx = pq_x[COORD_WIDTH] ? qp_x[COORD_WIDTH-1:0] : pq_x[COORD_WIDTH-1:0];
        n_dy = pq_y[COORD_WIDTH] ? qp_y[COORD_WIDTH-1:0] : pq_y[COORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_rs  <= i_rs;
        end
    end

    assign o_ctl = r_ctl;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;
    assign o_rs  = r_rs;

endmodule

>>> sv/ctbc_square.sv
module ctbc_square
    import ctbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_ctl                       i_ctl,
    input  logic [COORD_WIDTH-1:0]     i_dx,
    input  logic [COORD_WIDTH-1:0]     i_dy,
    input  logic [COORD_WIDTH-1:0]     i_rs,
    output t_ctl                       o_ctl,
    output logic [2*COORD_WIDTH-1:0]   o_sx,
    output logic [2*COORD_WIDTH-1:0]   o_sy,
    output logic [2*COORD_WIDTH-1:0]   o_rr
);

    localparam int SQ_WIDTH = 2 * COORD_WIDTH;

    logic [SQ_WIDTH-1:0] n_sx, n_sy, n_rr, r_sx, r_sy, r_rr;
    t_ctl                r_ctl;

    assign n_sx = SQ_WIDTH'(i_dx) * SQ_WIDTH'(i_dx);
    assign n_sy = SQ_WIDTH'(i_dy) * SQ_WIDTH'(i_dy);
    assign n_rr = SQ_WIDTH'(i_rs) * SQ_WIDTH'(i_rs);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_rr  <= n_rr;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sx  = r_sx;
    assign o_sy  = r_sy;
    assign o_rr  = r_rr;

endmodule

>>> sv/ctbc_compare.sv
module ctbc_compare
    import ctbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_ctl                       i_ctl,
    input  logic [2*COORD_WIDTH-1:0]   i_sx,
    input  logic [2*COORD_WIDTH-1:0]   i_sy,
    input  logic [2*COORD_WIDTH-1:0]   i_rr,
    output logic                       o_hit
);

    localparam int SUM_WIDTH = 2 * COORD_WIDTH + 1;

    logic [SUM_WIDTH-1:0] dist_sq;
    logic                 n_hit, r_hit;

    always_comb begin
        dist_sq = SUM_WIDTH'(i_sx) + SUM_WIDTH'(i_sy);
        case (i_ctl.mode)
            MODE_BOX_BOX: begin
                n_hit = i_ctl.box_hit;
            end
            MODE_CIRCLE_CIRCLE, MODE_BOX_CIRCLE: begin
                n_hit = dist_sq < SUM_WIDTH'(i_rr);
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

>>> sv/collision_test_box_circle.sv
// four register stages (clamp, abs diff, square, compare) lie between an accepted input
// transaction and o_valid; throughput: one transaction per cycle unless the sink stalls;
// each stage has its own valid bit, so bubbles close up under stall
// reset: synchronous active-low i_rst_n clears the stage valid bits only;
// the datapath registers are not reset
module collision_test_box_circle
    import ctbc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_a_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_hi_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_hi_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit
);

    logic [NUM_STAGES-1:0] r_v, n_v, stage_en;

    t_ctl                          ctl1, ctl2, ctl3;
    logic signed [COORD_WIDTH-1:0] px, qx, py, qy;
    logic [COORD_WIDTH-1:0]        rs1, rs2, dx, dy;
    logic [2*COORD_WIDTH-1:0]      sx, sy, rr;

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        stage_en[NUM_STAGES-1] = i_ready | ~r_v[NUM_STAGES-1];
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = stage_en[k+1] | ~r_v[k];
        end
        n_v = r_v;
        if (stage_en[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready = stage_en[0];
    assign o_valid = r_v[NUM_STAGES-1];

    ctbc_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp (
        .i_clk    (i_clk),
        .i_en     (stage_en[0]),
        .i_mode   (i_mode),
        .i_a_lo_x (i_a_lo_x),
        .i_a_lo_y (i_a_lo_y),
        .i_a_hi_x (i_a_hi_x),
        .i_a_hi_y (i_a_hi_y),
        .i_b_lo_x (i_b_lo_x),
        .i_b_lo_y (i_b_lo_y),
        .i_b_hi_x (i_b_hi_x),
        .i_b_hi_y (i_b_hi_y),
        .o_ctl    (ctl1),
        .o_px     (px),
        .o_qx     (qx),
        .o_py     (py),
        .o_qy     (qy),
        .o_rs     (rs1)
    );

    ctbc_absdiff #(.COORD_WIDTH(COORD_WIDTH)) u_absdiff (
        .i_clk (i_clk),
        .i_en  (stage_en[1]),
        .i_ctl (ctl1),
        .i_px  (px),
        .i_qx  (qx),
        .i_py  (py),
        .i_qy  (qy),
        .i_rs  (rs1),
        .o_ctl (ctl2),
        .o_dx  (dx),
        .o_dy  (dy),
        .o_rs  (rs2)
    );

    ctbc_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
        .i_clk (i_clk),
        .i_en  (stage_en[2]),
        .i_ctl (ctl2),
        .i_dx  (dx),
        .i_dy  (dy),
        .i_rs  (rs2),
        .o_ctl (ctl3),
        .o_sx  (sx),
        .o_sy  (sy),
        .o_rr  (rr)
    );

    ctbc_compare #(.COORD_WIDTH(COORD_WIDTH)) u_compare (
        .i_clk (i_clk),
        .i_en  (stage_en[3]),
        .i_ctl (ctl3),
        .i_sx  (sx),
        .i_sy  (sy),
        .i_rr  (rr),
        .o_hit (o_hit)
    );

endmodule

>>> sv/ctbc_checker.sv
module ctbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_hit
);

    // held result stays put while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit))
        else $error("result dropped or changed under stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // the pipe only pushes back when the output is full and stalled
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready || !o_valid |-> o_ready)
        else $error("input refused with room in the pipe");

    // an unstalled transaction reaches o_valid once it has passed every stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("result missing after pipeline latency");

endmodule

bind collision_test_box_circle ctbc_checker u_ctbc_checker (.*);

>>> test/collision_test_box_circle_tb.sv
`timescale 1ns / 1ps

module collision_test_box_circle_tb
    import ctbc_pkg::*;
();

    localparam int COORD_W = 24;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [COORD_W-1:0] t_coord;

    // box: lo/hi corners; circle: lo is the centre, hi_x the radius, hi_y unused
    typedef struct {
        t_coord lo_x;
        t_coord lo_y;
        t_coord hi_x;
        t_coord hi_y;
    } t_shape;

    typedef struct {
        logic [1:0] mode;
        t_shape     a;
        t_shape     b;
    } t_pair;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_ready;
    logic [1:0]   i_mode = '0;
    t_coord       i_a_lo_x = '0;
    t_coord       i_a_lo_y = '0;
    t_coord       i_a_hi_x = '0;
    t_coord       i_a_hi_y = '0;
    t_coord       i_b_lo_x = '0;
    t_coord       i_b_lo_y = '0;
    t_coord       i_b_hi_x = '0;
    t_coord       i_b_hi_y = '0;
    logic         o_valid;
    logic         i_ready = 1'b0;
    logic         o_hit;

    bit           expected_hits[$];
    bit           exp_hit;
    int           mismatch_cnt = 0;
    int           cycle_cnt = 0;
    int           burst_left = 0;
    int           rx_cycle = 0;
    int           rx_pattern = 0;

    collision_test_box_circle #(
        .COORD_WIDTH(COORD_W)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_a_lo_x (i_a_lo_x),
        .i_a_lo_y (i_a_lo_y),
        .i_a_hi_x (i_a_hi_x),
        .i_a_hi_y (i_a_hi_y),
        .i_b_lo_x (i_b_lo_x),
        .i_b_lo_y (i_b_lo_y),
        .i_b_hi_x (i_b_hi_x),
        .i_b_hi_y (i_b_hi_y),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_hit    (o_hit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: drives i_ready from one of four stall patterns, picked anew at random
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 200 == 0) begin
            rx_pattern <= $urandom_range(0, 3);
        end
        case (rx_pattern)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (rx_cycle % 4 == 0);
            default: i_ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    function automatic longint sq_dist(longint p, longint q);
        longint d;
        d = (p >= q) ? p - q : q - p;
        return d * d;
    endfunction

    function automatic longint clamp_into(longint v, longint lo, longint hi);
        longint t;
        t = (v < hi) ? v : hi;
        return (lo > t) ? lo : t;
    endfunction

    function automatic bit overlap_hit(t_pair p);
        longint alx, aly, ahx, ahy, blx, bly, bhx, bhy;
        longint dist_sq, rad, cx, cy;
        alx = p.a.lo_x;
        aly = p.a.lo_y;
        ahx = p.a.hi_x;
        ahy = p.a.hi_y;
        blx = p.b.lo_x;
        bly = p.b.lo_y;
        bhx = p.b.hi_x;
        bhy = p.b.hi_y;
        case (p.mode)
            MODE_BOX_BOX: begin
                return !((ahx < blx) || (alx > bhx) || (ahy < bly) || (aly > bhy));
            end
            MODE_CIRCLE_CIRCLE: begin
                dist_sq = sq_dist(alx, blx) + sq_dist(aly, bly);
                // negative radii count as zero
                rad = ((ahx < 0) ? 0 : ahx) + ((bhx < 0) ? 0 : bhx);
                return dist_sq < rad * rad;
            end
            MODE_BOX_CIRCLE: begin
                cx = clamp_into(blx, alx, ahx);
                cy = clamp_into(bly, aly, ahy);
                dist_sq = sq_dist(blx, cx) + sq_dist(bly, cy);
                rad = (bhx < 0) ? 0 : bhx;
                return dist_sq < rad * rad;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_pair make_pair(logic [1:0] mode, int alx, int aly, int ahx, int ahy,
                                        int blx, int bly, int bhx, int bhy);
        t_pair p;
        p.mode   = mode;
        p.a.lo_x = COORD_W'(alx);
        p.a.lo_y = COORD_W'(aly);
        p.a.hi_x = COORD_W'(ahx);
        p.a.hi_y = COORD_W'(ahy);
        p.b.lo_x = COORD_W'(blx);
        p.b.lo_y = COORD_W'(bly);
        p.b.hi_x = COORD_W'(bhx);
        p.b.hi_y = COORD_W'(bhy);
        return p;
    endfunction

    function automatic t_coord near(t_coord base, int span);
        return COORD_W'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // shape placed around base; wraps at the coordinate range like the hardware
    function automatic t_shape rand_shape(bit is_box, t_coord base, int span);
        t_shape s;
        t_coord tmp;
        int     r;
        s.lo_x = near(base, span);
        s.lo_y = near(base, span);
        if (is_box) begin
            s.hi_x = COORD_W'(int'(s.lo_x) + int'($urandom_range(0, span)));
            s.hi_y = COORD_W'(int'(s.lo_y) + int'($urandom_range(0, span)));
            if ($urandom_range(0, 15) == 0) begin
                tmp = s.lo_x;
                s.lo_x = s.hi_x;
                s.hi_x = tmp;
            end
            if ($urandom_range(0, 15) == 0) begin
                tmp = s.lo_y;
                s.lo_y = s.hi_y;
                s.hi_y = tmp;
            end
        end else begin
            r = $urandom_range(0, span);
            if ($urandom_range(0, 15) == 0) begin
                r = -r - 1;
            end
            s.hi_x = COORD_W'(r);
            s.hi_y = COORD_W'($urandom);
        end
        return s;
    endfunction

    task automatic send_pair(t_pair p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_mode   <= p.mode;
        i_a_lo_x <= p.a.lo_x;
        i_a_lo_y <= p.a.lo_y;
        i_a_hi_x <= p.a.hi_x;
        i_a_hi_y <= p.a.hi_y;
        i_b_lo_x <= p.b.lo_x;
        i_b_lo_y <= p.b.lo_y;
        i_b_hi_x <= p.b.hi_x;
        i_b_hi_y <= p.b.hi_y;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        expected_hits = {expected_hits, overlap_hit(p)};
    endtask

    // result side: sampled mid-cycle, the transaction completes at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_hits.size() == 0) begin
                $error("hit: expected none, actual %0b", o_hit);
                mismatch_cnt++;
            end else begin
                exp_hit = expected_hits.pop_front();
                if (o_hit !== exp_hit) begin
                    $error("hit: expected %0b, actual %0b", exp_hit, o_hit);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic test_box_box;
        // touching edges hit, one lsb apart misses
        send_pair(make_pair(MODE_BOX_BOX, 0, 0, 256, 256, 256, 0, 512, 256));
        send_pair(make_pair(MODE_BOX_BOX, 0, 0, 256, 256, 257, 0, 512, 256));
        send_pair(make_pair(MODE_BOX_BOX, 0, 0, 256, 256, 0, -512, 256, -1));
        send_pair(make_pair(MODE_BOX_BOX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            -100, 300, -50, 400));
        // inverted box is used as given
        send_pair(make_pair(MODE_BOX_BOX, 512, 512, 0, 0, 100, 100, 200, 200));
    endtask

    task automatic test_circle_circle;
        // tangent circles miss, one lsb closer hits
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, 0, 0, 300, 7, 500, 0, 200, -9));
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, 0, 0, 300, 7, 499, 0, 200, -9));
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, 10, 10, 0, 0, 10, 10, 0, 0));
        // negative radius acts as zero
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, 0, 0, -1000, 0, 5, 5, 8, 0));
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, COORD_MIN, COORD_MIN, COORD_MAX, 0,
                            COORD_MAX, COORD_MAX, COORD_MAX, 0));
    endtask

    task automatic test_box_circle;
        send_pair(make_pair(MODE_BOX_CIRCLE, -256, -256, 256, 256, 10, 20, 1, 0));
        // zero radius inside the box still misses
        send_pair(make_pair(MODE_BOX_CIRCLE, -256, -256, 256, 256, 10, 20, 0, 0));
        // corner: distance squared 3*3+4*4 against radius 5 then 6
        send_pair(make_pair(MODE_BOX_CIRCLE, 0, 0, 100, 100, 103, 104, 5, 0));
        send_pair(make_pair(MODE_BOX_CIRCLE, 0, 0, 100, 100, 103, 104, 6, 0));
        send_pair(make_pair(MODE_BOX_CIRCLE, 100, 100, 0, 0, 50, 50, 60, 0));
        send_pair(make_pair(MODE_BOX_CIRCLE, 0, 0, 100, 100, 50, 50, COORD_MIN, 0));
    endtask

    task automatic test_unused_mode;
        send_pair(make_pair(MODE_UNUSED, 0, 0, 100, 100, 0, 0, 100, 100));
        send_pair(make_pair(MODE_UNUSED, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    endtask

    task automatic test_field_extremes;
        send_pair(make_pair(MODE_BOX_BOX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_pair(make_pair(MODE_CIRCLE_CIRCLE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_pair(make_pair(MODE_BOX_CIRCLE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    endtask

    task automatic test_random_mix(int count);
        t_pair  p;
        t_coord base;
        int     span;
        int     pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 15);
            p.mode = (pick < 5) ? MODE_BOX_BOX : (pick < 10) ? MODE_CIRCLE_CIRCLE :
                     (pick < 15) ? MODE_BOX_CIRCLE : MODE_UNUSED;
            if ($urandom_range(0, 9) == 0) begin
                // raw noise across all bits
                p.a = '{COORD_W'($urandom), COORD_W'($urandom),
                        COORD_W'($urandom), COORD_W'($urandom)};
                p.b = '{COORD_W'($urandom), COORD_W'($urandom),
                        COORD_W'($urandom), COORD_W'($urandom)};
            end else begin
                base = COORD_W'($urandom);
                span = 1 << $urandom_range(3, 20);
                p.a = rand_shape(p.mode != MODE_CIRCLE_CIRCLE, base, span);
                p.b = rand_shape(p.mode == MODE_BOX_BOX, base, span);
            end
            send_pair(p);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_box_box();
        test_circle_circle();
        test_box_circle();
        test_unused_mode();
        test_field_extremes();
        test_random_mix(1350);
        i_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (4 * NUM_STAGES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
